### sv/spcc_pkg.sv
`timescale 1ns / 1ps
// shared pair-kind codes for the shape pair collision contact core
package spcc_pkg;

  localparam logic [1:0] CMD_BOX_BOX   = 2'd0;
  localparam logic [1:0] CMD_CIRC_CIRC = 2'd1;
  localparam logic [1:0] CMD_CIRC_BOX  = 2'd2;

endpackage

### sv/spcc_front.sv
`timescale 1ns / 1ps
// front pipeline: offsets, hit tests and start values of the rounding lanes
module spcc_front #(
  parameter int CW = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [((10*CW-6)+7)/8*8-1:0] in_data,
  input  logic [1:0]               in_cmd,
  output logic                     valid_o,
  output logic [10*CW-4:0]         side_o,
  output logic signed [4*CW+3:0]   res_o [4],
  output logic signed [4*CW+3:0]   u_o,
  output logic [2*CW:0]            s_o,
  output logic [CW-2:0]            rad_o [4]
);
  import spcc_pkg::*;

  localparam int WW = 4*CW+4;

  typedef struct packed {
    logic [1:0]           cmd;
    logic                 hit;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic [CW-3:0]        hax;
    logic [CW-3:0]        hay;
    logic [CW-3:0]        hbx;
    logic [CW-3:0]        hby;
  } side_t;

  // input slicing
  logic signed [CW-1:0] ax, ay, bx, by;
  logic [CW-2:0]        aw, ah, ar, bw, bh, br;
  assign ax = in_data[0 +: CW];
  assign ay = in_data[CW +: CW];
  assign aw = in_data[2*CW +: CW-1];
  assign ah = in_data[3*CW-1 +: CW-1];
  assign ar = in_data[4*CW-2 +: CW-1];
  assign bx = in_data[5*CW-3 +: CW];
  assign by = in_data[6*CW-3 +: CW];
  assign bw = in_data[7*CW-3 +: CW-1];
  assign bh = in_data[8*CW-4 +: CW-1];
  assign br = in_data[9*CW-5 +: CW-1];

  // valid chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end
  assign valid_o = v6_r;

  // stage 1: center offsets and magnitudes
  logic signed [CW:0] dx_nxt, dy_nxt;
  logic [CW-1:0]      mdx_nxt, mdy_nxt;
  side_t              side1_nxt;
  always_comb begin
    dx_nxt  = {bx[CW-1], bx} - {ax[CW-1], ax};
    dy_nxt  = {by[CW-1], by} - {ay[CW-1], ay};
    mdx_nxt = dx_nxt[CW] ? CW'(-dx_nxt) : CW'(dx_nxt);
    mdy_nxt = dy_nxt[CW] ? CW'(-dy_nxt) : CW'(dy_nxt);
    side1_nxt.cmd = in_cmd;
    side1_nxt.hit = 1'b0;
    side1_nxt.ax  = ax;
    side1_nxt.ay  = ay;
    side1_nxt.bx  = bx;
    side1_nxt.by  = by;
    side1_nxt.dx  = dx_nxt;
    side1_nxt.dy  = dy_nxt;
    side1_nxt.hax = aw[CW-2:1];
    side1_nxt.hay = ah[CW-2:1];
    side1_nxt.hbx = bw[CW-2:1];
    side1_nxt.hby = bh[CW-2:1];
  end

  logic [CW-1:0] mdx1_r, mdy1_r;
  logic [CW-2:0] aw1_r, ah1_r, ar1_r, bw1_r, bh1_r, br1_r;
  side_t         side1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mdx1_r  <= mdx_nxt;
      mdy1_r  <= mdy_nxt;
      aw1_r   <= aw;
      ah1_r   <= ah;
      ar1_r   <= ar;
      bw1_r   <= bw;
      bh1_r   <= bh;
      br1_r   <= br;
      side1_r <= side1_nxt;
    end
  end

  // stage 2: box overlap, radius sum, circle-box excess per axis
  logic          hitbb_nxt;
  logic [CW-1:0] rsum_nxt, ra_nxt;
  logic [CW:0]   mex_nxt, mey_nxt, tdx, tdy;
  always_comb begin
    tdx       = {mdx1_r, 1'b0};
    tdy       = {mdy1_r, 1'b0};
    hitbb_nxt = (tdx <= (CW+1)'(CW'(aw1_r) + CW'(bw1_r))) &&
                (tdy <= (CW+1)'(CW'(ah1_r) + CW'(bh1_r)));
    rsum_nxt  = CW'(ar1_r) + CW'(br1_r);
    ra_nxt    = {ar1_r, 1'b0};
    mex_nxt   = (tdx > (CW+1)'(bw1_r)) ? tdx - (CW+1)'(bw1_r) : '0;
    mey_nxt   = (tdy > (CW+1)'(bh1_r)) ? tdy - (CW+1)'(bh1_r) : '0;
  end

  logic          hitbb2_r;
  logic [CW-1:0] rsum2_r, ra2_r, mdx2_r, mdy2_r;
  logic [CW:0]   mex2_r, mey2_r;
  logic [CW-2:0] ar2_r, br2_r;
  side_t         side2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      hitbb2_r <= hitbb_nxt;
      rsum2_r  <= rsum_nxt;
      ra2_r    <= ra_nxt;
      mex2_r   <= mex_nxt;
      mey2_r   <= mey_nxt;
      mdx2_r   <= mdx1_r;
      mdy2_r   <= mdy1_r;
      ar2_r    <= ar1_r;
      br2_r    <= br1_r;
      side2_r  <= side1_r;
    end
  end

  // stage 3: squares and radius products
  logic [2*CW-1:0] sqx_nxt, sqy_nxt, rs_nxt, ras_nxt;
  logic [2*CW+1:0] ex_nxt, ey_nxt;
  always_comb begin
    sqx_nxt = mdx2_r * mdx2_r;
    sqy_nxt = mdy2_r * mdy2_r;
    rs_nxt  = rsum2_r * rsum2_r;
    ras_nxt = ra2_r * ra2_r;
    ex_nxt  = mex2_r * mex2_r;
    ey_nxt  = mey2_r * mey2_r;
  end

  logic [2*CW-1:0] sqx3_r, sqy3_r, rs3_r, ras3_r;
  logic [2*CW+1:0] ex3_r, ey3_r;
  logic            hitbb3_r;
  side_t           side3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx3_r   <= sqx_nxt;
      sqy3_r   <= sqy_nxt;
      rs3_r    <= rs_nxt;
      ras3_r   <= ras_nxt;
      ex3_r    <= ex_nxt;
      ey3_r    <= ey_nxt;
      hitbb3_r <= hitbb2_r;
      side3_r  <= side2_r;
    end
  end

  // stage 4: hit decision
  logic [2*CW:0]   s_nxt;
  logic [2*CW+2:0] e_nxt;
  side_t           side4_nxt;
  always_comb begin
    s_nxt     = (2*CW+1)'(sqx3_r) + (2*CW+1)'(sqy3_r);
    e_nxt     = (2*CW+3)'(ex3_r) + (2*CW+3)'(ey3_r);
    side4_nxt = side3_r;
    case (side3_r.cmd)
      CMD_BOX_BOX:   side4_nxt.hit = hitbb3_r;
      CMD_CIRC_CIRC: side4_nxt.hit = s_nxt <= (2*CW+1)'(rs3_r);
      CMD_CIRC_BOX:  side4_nxt.hit = e_nxt <= (2*CW+3)'(ras3_r);
      default:       side4_nxt.hit = 1'b0;
    endcase
  end

  logic [2*CW:0] s4_r, s5_r, s6_r;
  side_t         side4_r, side5_r, side6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_r    <= s_nxt;
      side4_r <= side4_nxt;
      s5_r    <= s4_r;
      side5_r <= side4_r;
      s6_r    <= s5_r;
      side6_r <= side5_r;
    end
  end

  // per lane: radius times offset, its square in parts, residual start
  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [CW-2:0]   rad3_r, rad4_r, rad5_r, rad6_r;
    logic [2*CW-2:0] prod_nxt, prod3_r;
    logic [CW-2:0]   xh;
    logic [CW-1:0]   xl;
    logic [2*CW-3:0] hh_nxt, hh4_r;
    logic [2*CW-2:0] hl_nxt, hl4_r;
    logic [2*CW-1:0] ll_nxt, ll4_r;
    logic [4*CW-1:0] t_nxt, t5_r;
    logic signed [WW-1:0] res_nxt, res6_r;

    always_comb begin
      if (g < 2) begin
        prod_nxt = (g % 2 == 0) ? ar2_r * mdx2_r : ar2_r * mdy2_r;
      end else begin
        prod_nxt = (g % 2 == 0) ? br2_r * mdx2_r : br2_r * mdy2_r;
      end
      xh      = prod3_r[2*CW-2:CW];
      xl      = prod3_r[CW-1:0];
      hh_nxt  = xh * xh;
      hl_nxt  = xh * xl;
      ll_nxt  = xl * xl;
      t_nxt   = (((4*CW)'(hh4_r) << (2*CW)) + ((4*CW)'(hl4_r) << (CW+1)) +
                 (4*CW)'(ll4_r)) << 2;
      res_nxt = signed'(WW'(t5_r) - WW'(s5_r));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad3_r  <= (g < 2) ? ar2_r : br2_r;
        prod3_r <= prod_nxt;
        rad4_r  <= rad3_r;
        hh4_r   <= hh_nxt;
        hl4_r   <= hl_nxt;
        ll4_r   <= ll_nxt;
        rad5_r  <= rad4_r;
        t5_r    <= t_nxt;
        rad6_r  <= rad5_r;
        res6_r  <= res_nxt;
      end
    end

    assign res_o[g] = res6_r;
    assign rad_o[g] = rad6_r;
  end

  logic signed [WW-1:0] u_nxt, u6_r;
  assign u_nxt = signed'(WW'(0) - WW'(s5_r));
  always_ff @(posedge clk) begin
    if (en) begin
      u6_r <= u_nxt;
    end
  end

  assign u_o    = u6_r;
  assign s_o    = s6_r;
  assign side_o = side6_r;

endmodule

### sv/spcc_lane.sv
`timescale 1ns / 1ps
// bit-serial rounding lane: one result bit per stage, shift-add residual update
module spcc_lane #(
  parameter int CW = 24
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [CW-2:0]          rad_i,
  input  logic [2*CW:0]          s_i,
  input  logic signed [4*CW+3:0] res_i,
  input  logic signed [4*CW+3:0] u_i,
  output logic [CW-2:0]          n_o
);

  localparam int WW = 4*CW+4;
  localparam int ST = CW-1;

  logic signed [WW-1:0] res_r [ST];
  logic signed [WW-1:0] u_r   [ST];
  logic [CW-2:0]        n_r   [ST];
  logic [CW-2:0]        rad_r [ST];
  logic [2*CW:0]        s_r   [ST];

  for (genvar g = 0; g < ST; g++) begin : g_step
    localparam int K = ST-1-g;
    logic signed [WW-1:0] res_p, u_p, delta, cand, res_nxt, u_nxt;
    logic [CW-2:0]        n_p, rad_p, c, n_nxt;
    logic [2*CW:0]        s_p;
    logic                 ok;

    if (g == 0) begin : g_first
      assign res_p = res_i;
      assign u_p   = u_i;
      assign n_p   = '0;
      assign rad_p = rad_i;
      assign s_p   = s_i;
    end else begin : g_next
      assign res_p = res_r[g-1];
      assign u_p   = u_r[g-1];
      assign n_p   = n_r[g-1];
      assign rad_p = rad_r[g-1];
      assign s_p   = s_r[g-1];
    end

    always_comb begin
      c       = n_p | ((CW-1)'(1) << K);
      delta   = signed'((u_p <<< (K+2)) + (WW'(s_p) << (2*K+2)));
      cand    = res_p - delta;
      ok      = !cand[WW-1] && (c <= rad_p);
      res_nxt = ok ? cand : res_p;
      u_nxt   = ok ? signed'(u_p + (WW'(s_p) << (K+1))) : u_p;
      n_nxt   = ok ? c : n_p;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[g] <= res_nxt;
        u_r[g]   <= u_nxt;
        n_r[g]   <= n_nxt;
        rad_r[g] <= rad_p;
        s_r[g]   <= s_p;
      end
    end
  end

  assign n_o = n_r[ST-1];

endmodule

### sv/spcc_back.sv
`timescale 1ns / 1ps
// side data delay line, contact point assembly with saturation, output register
module spcc_back #(
  parameter int CW = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [10*CW-4:0]             side_i,
  input  logic [CW-2:0]                n_i [4],
  output logic                         out_tvalid,
  output logic [(4*CW+7)/8*8-1:0]      out_tdata,
  output logic [0:0]                   out_tuser
);
  import spcc_pkg::*;

  localparam int ST = CW-1;
  localparam int OW = (4*CW+7)/8*8;

  typedef struct packed {
    logic [1:0]           cmd;
    logic                 hit;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic [CW-3:0]        hax;
    logic [CW-3:0]        hay;
    logic [CW-3:0]        hbx;
    logic [CW-3:0]        hby;
  } side_t;

  side_t sd_r [ST];
  logic  vd_r [ST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ST; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (en) begin
      vd_r[0] <= in_valid;
      for (int i = 1; i < ST; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_i;
      for (int i = 1; i < ST; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  function automatic logic signed [CW+1:0] clampv(input logic signed [CW+1:0] d,
                                                 input logic [CW-3:0] h);
    logic signed [CW+1:0] hs;
    hs = signed'((CW+2)'(h));
    if (d > hs) return hs;
    if (d < -hs) return -hs;
    return d;
  endfunction

  function automatic logic signed [CW+1:0] circv(input logic signed [CW:0] d,
                                                input logic [CW-2:0] n,
                                                input logic flip);
    logic signed [CW+1:0] m;
    m = signed'((CW+2)'(n));
    if (d == '0) return '0;
    return (d[CW] ^ flip) ? -m : m;
  endfunction

  function automatic logic [CW-1:0] satv(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] hi, lo;
    hi = signed'((CW+2)'({1'b0, {(CW-1){1'b1}}}));
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  side_t                sd;
  logic signed [CW+1:0] dx2, dy2, oax, oay, obx, oby;
  logic [CW-1:0]        cax, cay, cbx, cby;
  logic [OW-1:0]        data_nxt;
  logic                 hit_nxt;

  always_comb begin
    sd  = sd_r[ST-1];
    dx2 = (CW+2)'(sd.dx);
    dy2 = (CW+2)'(sd.dy);
    if (sd.cmd == CMD_BOX_BOX) begin
      oax = clampv(dx2, sd.hax);
      oay = clampv(dy2, sd.hay);
    end else begin
      oax = circv(sd.dx, n_i[0], 1'b0);
      oay = circv(sd.dy, n_i[1], 1'b0);
    end
    if (sd.cmd == CMD_CIRC_CIRC) begin
      obx = circv(sd.dx, n_i[2], 1'b1);
      oby = circv(sd.dy, n_i[3], 1'b1);
    end else begin
      obx = clampv(-dx2, sd.hbx);
      oby = clampv(-dy2, sd.hby);
    end
    cax      = satv((CW+2)'(sd.ax) + oax);
    cay      = satv((CW+2)'(sd.ay) + oay);
    cbx      = satv((CW+2)'(sd.bx) + obx);
    cby      = satv((CW+2)'(sd.by) + oby);
    hit_nxt  = sd.hit;
    data_nxt = hit_nxt ? OW'({cby, cbx, cay, cax}) : '0;
  end

  logic          out_tvalid_r;
  logic [OW-1:0] out_tdata_r;
  logic          out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vd_r[ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= data_nxt;
      out_tuser_r <= hit_nxt;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule

### sv/shape_pair_collision_contact_core.sv
`timescale 1ns / 1ps
// top level of the shape pair collision contact core
//
//  channel | direction | tdata                                   | tuser
//  in_     | slave     | a center x/y, a w/h/r, b center x/y,    | pair kind
//          |           | b w/h/r                                 |
//  out_    | master    | contact a x/y, contact b x/y            | collided
//
// one word per cycle in and out while out_tready does not stall the output;
// the bit-serial rounding lanes produce one result bit per stage
// synchronous active-low reset clears all valid bits; payload is not reset
// the whole pipeline advances when the output register is empty or taken,
// so a stall on out_tready holds every stage and drops in_tready
module shape_pair_collision_contact_core #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // a_center_x, a_center_y, a_width, a_height, a_radius,
  // b_center_x, b_center_y, b_width, b_height, b_radius, zero fill
  input  logic [((10*COORD_WIDTH-6)+7)/8*8-1:0]  in_tdata,
  // command
  input  logic [1:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // contact_a_x, contact_a_y, contact_b_x, contact_b_y, zero fill
  output logic [(4*COORD_WIDTH+7)/8*8-1:0]       out_tdata,
  // collided
  output logic [0:0]                             out_tuser
);

  localparam int CW = COORD_WIDTH;

  logic                   en;
  logic                   fv;
  logic [10*CW-4:0]       side;
  logic signed [4*CW+3:0] res [4];
  logic signed [4*CW+3:0] u0;
  logic [2*CW:0]          s;
  logic [CW-2:0]          rad [4];
  logic [CW-2:0]          n   [4];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  spcc_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_cmd   (in_tuser),
    .valid_o  (fv),
    .side_o   (side),
    .res_o    (res),
    .u_o      (u0),
    .s_o      (s),
    .rad_o    (rad)
  );

  for (genvar g = 0; g < 4; g++) begin : g_lane
    spcc_lane #(.CW(CW)) u_lane (
      .clk   (clk),
      .en    (en),
      .rad_i (rad[g]),
      .s_i   (s),
      .res_i (res[g]),
      .u_i   (u0),
      .n_o   (n[g])
    );
  end

  spcc_back #(.CW(CW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (fv),
    .side_i     (side),
    .n_i        (n),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
